@@ sv/fssp_pkg.sv @@
// ----------------------------------------------------------------------------
// fssp_pkg: shared types and constants of the four slot score promotion core
// Entry layout, operation and status codes, and the request/status structs
// exchanged between the slot bank, the overflow list and the top level.
// ----------------------------------------------------------------------------
package fssp_pkg;

  localparam int NSLOT     = 4;
  localparam int SLOT_W    = 2;
  localparam int SIDX_W    = 3;
  localparam int ID_W      = 8;
  localparam int SCORE_W   = 16;
  localparam int OVF_DEPTH = 16;
  localparam int OVF_IDX_W = (OVF_DEPTH > 1) ? $clog2(OVF_DEPTH) : 1;
  localparam int LEN_W     = $clog2(OVF_DEPTH + 1);
  localparam int HELD_W    = $clog2(NSLOT + OVF_DEPTH + 1);
  localparam int CNT_W     = 5;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  localparam logic [SIDX_W-1:0] NO_SLOT = SIDX_W'(NSLOT);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [2:0] {
    OVF_HOLD,
    OVF_PUSH,
    OVF_UNLINK,
    OVF_SCORE,
    OVF_PROMOTE
  } ovf_op_e;

  typedef struct packed {
    ovf_op_e              op;
    logic [OVF_IDX_W-1:0] pos;
    entry_t               ent;
  } ovf_cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [OVF_IDX_W-1:0] pos;
    entry_t               head;
    logic [LEN_W-1:0]     len;
    logic                 full;
  } ovf_stat_t;

  typedef enum logic [1:0] {
    SLOT_HOLD,
    SLOT_FILL,
    SLOT_CLEAR,
    SLOT_SCORE
  } slot_op_e;

  typedef struct packed {
    slot_op_e          op;
    logic [SLOT_W-1:0] idx;
    entry_t            ent;
  } slot_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] weak_idx;
    logic              weak_empty;
    entry_t            weak_ent;
  } slot_stat_t;

  // Declared from the top field down so that changed lands in bit 0.
  typedef struct packed {
    logic              overflow_empty;
    logic              all_empty;
    logic [CNT_W-1:0]  entry_count;
    status_e           status;
    logic [ID_W-1:0]   moved_id;
    logic              moved_valid;
    logic [SIDX_W-1:0] slot_index;
    logic              changed;
  } result_t;

endpackage

@@ sv/fssp_slots.sv @@
// ----------------------------------------------------------------------------
// fssp_slots: the four primary slots
// Holds west, east, north and south entries, finds an id, the first empty
// slot and the weakest slot, and applies one slot request per cycle.
// ----------------------------------------------------------------------------
module fssp_slots
  import fssp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] key_id_i,
  input  slot_cmd_t       cmd_i,
  output slot_stat_t      stat_o
);

  logic   valid_q [NSLOT];
  entry_t ent_q   [NSLOT];

  always_comb begin
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] weak_idx;
    logic              weak_empty;
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    // Scan downward so the lowest matching slot wins.
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (valid_q[i] && ent_q[i].id == key_id_i) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    // An empty slot beats any score; among full slots the first lowest wins.
    weak_idx   = '0;
    weak_empty = !valid_q[0];
    for (int i = 1; i < NSLOT; i++) begin
      if (!valid_q[i] || (!weak_empty && ent_q[i].score < ent_q[weak_idx].score)) begin
        weak_idx   = SLOT_W'(i);
        weak_empty = !valid_q[i];
      end
    end
    stat_o.hit        = hit;
    stat_o.hit_idx    = hit_idx;
    stat_o.free_any   = free_any;
    stat_o.free_idx   = free_idx;
    stat_o.weak_idx   = weak_idx;
    stat_o.weak_empty = weak_empty;
    stat_o.weak_ent   = ent_q[weak_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) valid_q[i] <= 1'b0;
    end else begin
      case (cmd_i.op)
        SLOT_FILL:  valid_q[cmd_i.idx] <= 1'b1;
        SLOT_CLEAR: valid_q[cmd_i.idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      SLOT_FILL:  ent_q[cmd_i.idx] <= cmd_i.ent;
      SLOT_SCORE: ent_q[cmd_i.idx].score <= cmd_i.ent.score;
      default: ;
    endcase
  end

endmodule

@@ sv/fssp_ovf_list.sv @@
// ----------------------------------------------------------------------------
// fssp_ovf_list: ordered overflow list
// A shift-compacted register list with its head at position zero. Every
// position compares its id in parallel; pushes, unlinks and promotions move
// each entry by at most one place per cycle.
// ----------------------------------------------------------------------------
module fssp_ovf_list
  import fssp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] key_id_i,
  input  ovf_cmd_t        cmd_i,
  output ovf_stat_t       stat_o
);

  entry_t           ent_q [OVF_DEPTH];
  entry_t           ent_d [OVF_DEPTH];
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] len_d;

  always_comb begin
    logic                 hit;
    logic [OVF_IDX_W-1:0] pos;
    hit = 1'b0;
    pos = '0;
    for (int i = OVF_DEPTH - 1; i >= 0; i--) begin
      if (LEN_W'(i) < len_q && ent_q[i].id == key_id_i) begin
        hit = 1'b1;
        pos = OVF_IDX_W'(i);
      end
    end
    stat_o.hit  = hit;
    stat_o.pos  = pos;
    stat_o.head = ent_q[0];
    stat_o.len  = len_q;
    stat_o.full = (len_q == LEN_W'(OVF_DEPTH));
  end

  always_comb begin
    len_d = len_q;
    for (int i = 0; i < OVF_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      case (cmd_i.op)
        OVF_PUSH: begin
          ent_d[i] = (i == 0) ? cmd_i.ent : ent_q[OVF_IDX_W'((i + OVF_DEPTH - 1) % OVF_DEPTH)];
        end
        OVF_UNLINK: begin
          if (OVF_IDX_W'(i) >= cmd_i.pos && i < OVF_DEPTH - 1) begin
            ent_d[i] = ent_q[OVF_IDX_W'((i + 1) % OVF_DEPTH)];
          end
        end
        OVF_SCORE: begin
          if (OVF_IDX_W'(i) == cmd_i.pos) ent_d[i].score = cmd_i.ent.score;
        end
        OVF_PROMOTE: begin
          // The promoted entry leaves its place; the demoted one enters at the head.
          if (i == 0) begin
            ent_d[i] = cmd_i.ent;
          end else if (OVF_IDX_W'(i) <= cmd_i.pos) begin
            ent_d[i] = ent_q[OVF_IDX_W'((i + OVF_DEPTH - 1) % OVF_DEPTH)];
          end
        end
        default: ;
      endcase
    end
    case (cmd_i.op)
      OVF_PUSH:   len_d = len_q + 1'b1;
      OVF_UNLINK: len_d = len_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < OVF_DEPTH; i++) ent_q[i] <= ent_d[i];
  end

endmodule

@@ sv/four_slot_score_promotion_core.sv @@
// ----------------------------------------------------------------------------
// four_slot_score_promotion_core: four primary slots with an overflow list
// Top level: request register, operation decode and the result register.
// ----------------------------------------------------------------------------
// Each request is registered, decoded against the slot bank and the overflow
// list in combinational logic, and its result is registered, so a new request
// is taken every cycle while the result side keeps up. The throughput is set
// by the update of the slot and list registers, which every request reads and
// writes. Ids are searched in the slots west, east, north, south first and
// then in the overflow list from its head; the first match is acted on.
// Request: tuser carries the opcode. The result carries the status (ok,
// overflow list full, id not found) and entry counts.
// ----------------------------------------------------------------------------
module four_slot_score_promotion_core
  import fssp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] entry_id, [23:8] entry_score
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] changed, [3:1] slot_index, [4] moved_valid, [12:5] moved_id,
  // [14:13] status, [19:15] entry_count, [20] all_empty, [21] overflow_empty,
  // [23:22] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic               in_valid_q;
  logic [1:0]         op_q;
  entry_t             req_q;
  logic               out_valid_q;
  result_t            res_q;
  result_t            res_d;
  logic [HELD_W-1:0]  held_q;
  logic [HELD_W-1:0]  held_d;
  logic               out_ready;
  logic               fire;
  slot_cmd_t          slot_cmd;
  slot_stat_t         slot_stat;
  ovf_cmd_t           ovf_cmd;
  ovf_stat_t          ovf_stat;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(res_q);

  fssp_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_id_i (req_q.id),
    .cmd_i    (slot_cmd),
    .stat_o   (slot_stat)
  );

  fssp_ovf_list u_ovf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_id_i (req_q.id),
    .cmd_i    (ovf_cmd),
    .stat_o   (ovf_stat)
  );

  always_comb begin
    slot_cmd.op  = SLOT_HOLD;
    slot_cmd.idx = '0;
    slot_cmd.ent = req_q;
    ovf_cmd.op   = OVF_HOLD;
    ovf_cmd.pos  = ovf_stat.pos;
    ovf_cmd.ent  = req_q;
    held_d       = held_q;
    res_d        = '0;
    res_d.slot_index = NO_SLOT;
    res_d.status     = ST_OK;

    if (fire) begin
      case (op_q)
        OP_ADD: begin
          if (slot_stat.free_any) begin
            slot_cmd.op      = SLOT_FILL;
            slot_cmd.idx     = slot_stat.free_idx;
            res_d.changed    = 1'b1;
            res_d.slot_index = {1'b0, slot_stat.free_idx};
            held_d           = held_q + 1'b1;
          end else if (ovf_stat.full) begin
            res_d.status = ST_FULL;
          end else begin
            ovf_cmd.op = OVF_PUSH;
            held_d     = held_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot_stat.hit) begin
            slot_cmd.idx = slot_stat.hit_idx;
            if (ovf_stat.len != '0) begin
              // Refill the slot from the overflow head.
              slot_cmd.op       = SLOT_FILL;
              slot_cmd.ent      = ovf_stat.head;
              ovf_cmd.op        = OVF_UNLINK;
              ovf_cmd.pos       = '0;
              res_d.moved_valid = 1'b1;
              res_d.moved_id    = ovf_stat.head.id;
            end else begin
              slot_cmd.op = SLOT_CLEAR;
            end
            res_d.changed    = 1'b1;
            res_d.slot_index = {1'b0, slot_stat.hit_idx};
            held_d           = held_q - 1'b1;
          end else if (ovf_stat.hit) begin
            ovf_cmd.op = OVF_UNLINK;
            held_d     = held_q - 1'b1;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
        OP_UPDATE: begin
          if (slot_stat.hit) begin
            slot_cmd.op  = SLOT_SCORE;
            slot_cmd.idx = slot_stat.hit_idx;
          end else if (ovf_stat.hit) begin
            if (slot_stat.weak_empty || req_q.score > slot_stat.weak_ent.score) begin
              slot_cmd.op  = SLOT_FILL;
              slot_cmd.idx = slot_stat.weak_idx;
              if (slot_stat.weak_empty) begin
                ovf_cmd.op = OVF_UNLINK;
              end else begin
                // The displaced slot entry goes to the overflow head.
                ovf_cmd.op        = OVF_PROMOTE;
                ovf_cmd.ent       = slot_stat.weak_ent;
                res_d.moved_valid = 1'b1;
                res_d.moved_id    = slot_stat.weak_ent.id;
              end
              res_d.changed    = 1'b1;
              res_d.slot_index = {1'b0, slot_stat.weak_idx};
            end else begin
              ovf_cmd.op = OVF_SCORE;
            end
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end

    res_d.entry_count    = CNT_W'(held_d);
    res_d.all_empty      = (held_d == '0);
    res_d.overflow_empty = (held_d <= HELD_W'(NSLOT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= fire;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q        <= s_axis_tuser;
      req_q.id    <= s_axis_tdata[ID_W-1:0];
      req_q.score <= s_axis_tdata[ID_W+SCORE_W-1:ID_W];
    end
    if (fire) res_q <= res_d;
  end

endmodule

@@ tb/score_promotion_checker.sv @@
// ----------------------------------------------------------------------------
// score_promotion_checker: result checker for the four slot promotion core
// Watches both stream channels, keeps its own copy of the slots and the
// overflow list, predicts the result of every accepted request and compares
// each returned result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module score_promotion_checker
  import fssp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // [7:0] entry_id, [23:8] entry_score
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] changed, [3:1] slot_index, [4] moved_valid, [12:5] moved_id,
  // [14:13] status, [19:15] entry_count, [20] all_empty, [21] overflow_empty
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   fail_count,
  output int                   outstanding
);

  logic               slot_live [NSLOT];
  logic [ID_W-1:0]    slot_key  [NSLOT];
  logic [SCORE_W-1:0] slot_rank [NSLOT];
  entry_t             spill_q[$];
  logic [CNT_W-1:0]   held;
  result_t            outcome_q[$];
  int                 mismatches;

  assign fail_count = mismatches;

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (slot_live[i] && slot_key[i] == id) return i;
    return NSLOT;
  endfunction

  function automatic int spill_of(logic [ID_W-1:0] id);
    for (int i = 0; i < spill_q.size(); i++)
      if (spill_q[i].id == id) return i;
    return -1;
  endfunction

  task automatic apply_request(input logic [1:0] opcode, input logic [ID_W-1:0] id,
                               input logic [SCORE_W-1:0] score, output result_t res);
    int                 s;
    int                 p;
    int                 weak_slot;
    logic               weak_empty;
    logic [SCORE_W-1:0] weak_score;
    entry_t             demoted;
    logic               had;
    res = '0;
    res.slot_index = NO_SLOT;
    res.status = ST_OK;
    case (opcode)
      OP_ADD: begin
        s = 0;
        while (s < NSLOT && slot_live[s]) s++;
        if (s < NSLOT) begin
          slot_live[s] = 1'b1;
          slot_key[s] = id;
          slot_rank[s] = score;
          res.changed = 1'b1;
          res.slot_index = SIDX_W'(s);
          held++;
        end else if (spill_q.size() >= OVF_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          spill_q.push_front(entry_t'{id: id, score: score});
          held++;
        end
      end
      OP_REMOVE: begin
        s = slot_of(id);
        if (s < NSLOT) begin
          // A freed slot is refilled from the overflow head when there is one.
          if (spill_q.size() > 0) begin
            slot_key[s] = spill_q[0].id;
            slot_rank[s] = spill_q[0].score;
            res.moved_valid = 1'b1;
            res.moved_id = spill_q[0].id;
            void'(spill_q.pop_front());
          end else begin
            slot_live[s] = 1'b0;
          end
          res.changed = 1'b1;
          res.slot_index = SIDX_W'(s);
          held--;
        end else begin
          p = spill_of(id);
          if (p >= 0) begin
            spill_q.delete(p);
            held--;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
      end
      OP_UPDATE: begin
        s = slot_of(id);
        if (s < NSLOT) begin
          slot_rank[s] = score;
        end else begin
          p = spill_of(id);
          if (p < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            spill_q[p].score = score;
            // Last empty slot wins, else the first slot of lowest score.
            weak_slot = 0;
            weak_empty = !slot_live[0];
            weak_score = slot_rank[0];
            for (int i = 1; i < NSLOT; i++) begin
              if (!slot_live[i] || (!weak_empty && slot_rank[i] < weak_score)) begin
                weak_slot = i;
                weak_empty = !slot_live[i];
                weak_score = slot_rank[i];
              end
            end
            if (weak_empty || score > weak_score) begin
              had = slot_live[weak_slot];
              demoted = entry_t'{id: slot_key[weak_slot], score: slot_rank[weak_slot]};
              spill_q.delete(p);
              slot_live[weak_slot] = 1'b1;
              slot_key[weak_slot] = id;
              slot_rank[weak_slot] = score;
              if (had) begin
                spill_q.push_front(demoted);
                res.moved_valid = 1'b1;
                res.moved_id = demoted.id;
              end
              res.changed = 1'b1;
              res.slot_index = SIDX_W'(weak_slot);
            end
          end
        end
      end
      default: ;
    endcase
    res.entry_count = held;
    res.all_empty = (held == 0);
    res.overflow_empty = (held <= NSLOT);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t act_r;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_live[i] = 1'b0;
        slot_key[i] = '0;
        slot_rank[i] = '0;
      end
      spill_q.delete();
      outcome_q.delete();
      held = '0;
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tuser, s_axis_tdata[ID_W-1:0],
                      s_axis_tdata[ID_W+SCORE_W-1:ID_W], exp_r);
        outcome_q.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: result %0h with no request waiting", $time, m_axis_tdata);
        end else begin
          exp_r = outcome_q.pop_front();
          act_r = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
          check_field("changed", 16'(exp_r.changed), 16'(act_r.changed));
          check_field("slot_index", 16'(exp_r.slot_index), 16'(act_r.slot_index));
          check_field("moved_valid", 16'(exp_r.moved_valid), 16'(act_r.moved_valid));
          check_field("moved_id", 16'(exp_r.moved_id), 16'(act_r.moved_id));
          check_field("status", 16'(exp_r.status), 16'(act_r.status));
          check_field("entry_count", 16'(exp_r.entry_count), 16'(act_r.entry_count));
          check_field("all_empty", 16'(exp_r.all_empty), 16'(act_r.all_empty));
          check_field("overflow_empty", 16'(exp_r.overflow_empty),
                      16'(act_r.overflow_empty));
          check_field("pad", '0, 16'(m_axis_tdata[M_TDATA_W-1:$bits(result_t)]));
        end
      end
      outstanding <= outcome_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top of the four slot score promotion core
// Drives directed and random add, remove and score update requests with
// varying idle patterns on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb
  import fssp_pkg::*;
();

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  int                   fail_count;
  int                   outstanding;

  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   hold_asked;
  int                   hold_served;
  logic [ID_W-1:0]      id_pool [16];

  four_slot_score_promotion_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  score_promotion_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #4000000;
    $display("four_slot_score_promotion_core: mismatch");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    m_axis_tready = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_request(input op_e op, input logic [ID_W-1:0] id,
                              input logic [SCORE_W-1:0] score);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {score, id};
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // The count seen at an edge does not yet include that edge's update, so look only from the next edge.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    op_e                op;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    int                 roll;
    bit                 fill_mode;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 16; i++) id_pool[i] = ID_W'($urandom_range(255));
    fill_mode = 1'b1;
    for (int n = 0; n < count; n++) begin
      // Alternate growing and shrinking so the overflow list fills and empties.
      if (n % 48 == 47) fill_mode = !fill_mode;
      roll = $urandom_range(99);
      if (fill_mode)
        op = (roll < 60) ? OP_ADD : (roll < 80) ? OP_REMOVE : OP_UPDATE;
      else
        op = (roll < 15) ? OP_ADD : (roll < 65) ? OP_REMOVE : OP_UPDATE;
      if ($urandom_range(9) == 0) id = ID_W'($urandom_range(255));
      else id = id_pool[$urandom_range(15)];
      case ($urandom_range(9))
        0:       score = '0;
        1:       score = '1;
        2, 3:    score = SCORE_W'($urandom_range(3)) << 8;
        default: score = SCORE_W'($urandom_range(16'hFFFF));
      endcase
      send_request(op, id, score);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asked = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: unknown ids on an empty core, slot fills, overflow
    // pushes and duplicates, update with and without promotion, refill on
    // remove, unlink from the list and emptying a slot.
    send_request(OP_UPDATE, 8'd5, 16'h1234);
    send_request(OP_REMOVE, 8'd5, 16'h0000);
    send_request(OP_ADD, 8'h00, 16'h0000);
    send_request(OP_ADD, 8'hFF, 16'hFFFF);
    send_request(OP_ADD, 8'd1, 16'h0100);
    send_request(OP_ADD, 8'd2, 16'h0080);
    send_request(OP_ADD, 8'd3, 16'h0050);
    send_request(OP_ADD, 8'hFF, 16'h0001);
    send_request(OP_UPDATE, 8'd3, 16'h0000);
    send_request(OP_UPDATE, 8'd3, 16'h0200);
    send_request(OP_UPDATE, 8'd1, 16'h7FFF);
    send_request(OP_REMOVE, 8'hFF, 16'hFFFF);
    send_request(OP_REMOVE, 8'hFF, 16'h0000);
    send_request(OP_REMOVE, 8'd77, 16'h0000);
    send_request(OP_UPDATE, 8'd77, 16'hFFFF);
    send_request(OP_REMOVE, 8'd3, 16'h0000);
    send_request(OP_ADD, 8'd4, 16'hAAAA);
    send_request(OP_ADD, 8'd6, 16'h5555);
    send_request(OP_UPDATE, 8'd6, 16'hFFFF);
    send_request(OP_REMOVE, 8'd0, 16'h0000);
    send_request(OP_REMOVE, 8'd1, 16'h0000);
    send_request(OP_REMOVE, 8'd2, 16'h0000);
    send_request(OP_REMOVE, 8'd4, 16'h0000);
    send_request(OP_REMOVE, 8'd6, 16'h0000);
    wait_drain();

    run_random(500, 20, 77);
    wait_drain();
    run_random(500, 77, 20);
    // Hold the result side off while requests keep coming, to back up the core.
    hold_asked++;
    run_random(30, 0, 0);
    run_random(490, 0, 0);
    wait_drain();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0)
      $display("four_slot_score_promotion_core: match");
    else
      $display("four_slot_score_promotion_core: mismatch");
    $finish;
  end

endmodule
